>>> rtl/pda_pkg.sv
// Shared constants and widths for the Poisson deviance accumulator.
// No dependencies; used by poisson_deviance_accumulator.
package pda_pkg;

  // ln(2) as unsigned Q0.32
  localparam logic [31:0] LN2_Q032 = 32'hB172_17F8;

  localparam int CNT_W  = 32;  // Q16.16 count width
  localparam int BIN_W  = 8;   // bin number and used-bin counter
  localparam int SUM_W  = 56;  // running sum, signed Q40.16
  localparam int OUT_W  = 48;  // result, signed Q32.16
  localparam int TERM_W = 40;  // one bin term, signed
  localparam int MUL_W  = 33;  // signed operand width of the shared multiplier

  localparam logic [OUT_W-1:0] OUT_POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

>>> rtl/poisson_deviance_accumulator.sv
// Poisson deviance accumulator, top level and only module.
// Depends on pda_pkg for constants and widths.
//
// Usage:
//   Input requests carry one histogram bin each (observed and predicted
//   count, unsigned Q16.16, plus a last-bin marker). A request is taken when
//   in_valid is high and in_stall is low. Bins are numbered from 1; bins
//   below first_bin or above MAX_BINS, and bins with zero prediction, add
//   nothing. The request with in_last_bin set produces one result request:
//   twice the summed terms (signed Q32.16, saturated), a clip flag and the
//   number of bins summed. All other requests produce no output.
//   Work per bin: a skipped bin goes straight to the finish state, a zero
//   observation adds its prediction directly, and a full bin uses the
//   single shared multiplier for two logarithms, each a 5-step
//   normalization plus one squaring per fraction bit and an ln2 scaling,
//   then one product for n*(ln n - ln v).
//   The result sits in an output register; the next bin is accepted while
//   it waits. If the receiver still stalls when another last bin finishes,
//   the sequencer holds until the register frees.
//   Reset (synchronous, rst_n low) clears the sum, counters, flag and sets
//   first_bin to 1. cfg_we writes first_bin; write only while idle.
module poisson_deviance_accumulator #(
  parameter int MAX_BINS           = 128,
  parameter int LOG_FRACTION_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pda_pkg::BIN_W-1:0]         cfg_wdata,
  // bin requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pda_pkg::CNT_W-1:0]         in_observed_count,
  input  logic [pda_pkg::CNT_W-1:0]         in_predicted_count,
  input  logic                              in_last_bin,
  // result requests
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pda_pkg::OUT_W-1:0]  out_deviance,
  output logic                              out_saturated,
  output logic [pda_pkg::BIN_W-1:0]         out_bins_used
);

  localparam int F      = LOG_FRACTION_STEPS;
  localparam int LW     = F + 6;               // log2 / ln / diff width, signed
  localparam int STEP_W = $clog2(F + 1);
  localparam int CW     = pda_pkg::CNT_W;
  localparam int BW     = pda_pkg::BIN_W;
  localparam int SW     = pda_pkg::SUM_W;
  localparam int TW     = pda_pkg::TERM_W;
  localparam int MW     = pda_pkg::MUL_W;
  localparam int ACC_W  = SW + 2;
  localparam logic [BW-1:0]     MAX_BIN_B = BW'(MAX_BINS);
  localparam logic [STEP_W-1:0] LAST_SQ   = STEP_W'(F - 1);
  localparam logic [STEP_W-1:0] LAST_NORM = STEP_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_SQ, ST_LN, ST_MULT, ST_ACC, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [BW-1:0]            first_bin_r, first_bin_nxt;
  logic [BW-1:0]            bin_r, bin_nxt;
  logic [BW-1:0]            used_r, used_nxt;
  logic signed [SW-1:0]     sum_r, sum_nxt;
  logic                     clip_r, clip_nxt;

  logic [CW-1:0]            n_r, n_nxt;
  logic [CW-1:0]            v_r, v_nxt;
  logic                     last_r, last_nxt;
  logic [CW-1:0]            m_r, m_nxt;        // mantissa, normalized to Q1.31
  logic [4:0]               sh_r, sh_nxt;      // normalization shift total
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [F-1:0]             frac_r, frac_nxt;
  logic                     sel_v_r, sel_v_nxt; // second log (prediction)
  logic signed [LW-1:0]     ln_n_r, ln_n_nxt;
  logic signed [LW-1:0]     ln_v_r, ln_v_nxt;
  logic signed [TW-1:0]     term_r, term_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [pda_pkg::OUT_W-1:0] dev_r, dev_nxt;
  logic                         sat_r, sat_nxt;
  logic [BW-1:0]                used_out_r, used_out_nxt;

  // shared multiplier
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [2*MW-1:0]   product;

  logic signed [LW-1:0]     l2;
  logic signed [LW-1:0]     diff;
  logic [5:0]               int_part;

  assign int_part = 6'd15 - {1'b0, sh_r};      // p - 16
  assign l2       = {int_part, frac_r};
  assign diff     = ln_n_r - ln_v_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      ST_LN: begin
        mul_a = {{(MW-LW){l2[LW-1]}}, l2};
        mul_b = {1'b0, pda_pkg::LN2_Q032};
      end
      ST_MULT: begin
        mul_a = {1'b0, n_r};
        mul_b = {{(MW-LW){diff[LW-1]}}, diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // sequencer
  logic [BW-1:0]            bin_inc;
  logic                     bin_used;
  logic [4:0]               norm_amt;
  logic [CW-1:0]            top_mask;
  logic [CW:0]              m_sq;
  logic signed [TW-1:0]     v_minus_n;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [SW-47:0]           sum_hi;

  assign bin_inc   = (bin_r != {BW{1'b1}}) ? bin_r + 1'b1 : bin_r;
  assign bin_used  = (bin_inc >= first_bin_r) && (bin_inc <= MAX_BIN_B) &&
                     (in_predicted_count != '0);
  assign top_mask  = ~({CW{1'b1}} >> norm_amt);
  assign m_sq      = product[2*CW-1:CW-1];     // square >> 31
  assign v_minus_n = $signed({{(TW-CW){1'b0}}, v_r}) - $signed({{(TW-CW){1'b0}}, n_r});
  assign acc_sum   = {{(ACC_W-SW){sum_r[SW-1]}}, sum_r} +
                     {{(ACC_W-TW){term_r[TW-1]}}, term_r};
  assign sum_hi    = sum_r[SW-1:46];           // doubled sum fits iff all equal

  always_comb begin
    case (step_r)
      STEP_W'(0): norm_amt = 5'd16;
      STEP_W'(1): norm_amt = 5'd8;
      STEP_W'(2): norm_amt = 5'd4;
      STEP_W'(3): norm_amt = 5'd2;
      default:    norm_amt = 5'd1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    first_bin_nxt = first_bin_r;
    bin_nxt       = bin_r;
    used_nxt      = used_r;
    sum_nxt       = sum_r;
    clip_nxt      = clip_r;
    n_nxt         = n_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    m_nxt         = m_r;
    sh_nxt        = sh_r;
    step_nxt      = step_r;
    frac_nxt      = frac_r;
    sel_v_nxt     = sel_v_r;
    ln_n_nxt      = ln_n_r;
    ln_v_nxt      = ln_v_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && out_stall;
    dev_nxt       = dev_r;
    sat_nxt       = sat_r;
    used_out_nxt  = used_out_r;

    if (cfg_we) begin
      first_bin_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_observed_count;
          v_nxt    = in_predicted_count;
          last_nxt = in_last_bin;
          bin_nxt  = bin_inc;
          if (!bin_used) begin
            state_nxt = ST_FINISH;
          end else if (in_observed_count == '0) begin
            term_nxt  = $signed({{(TW-CW){1'b0}}, in_predicted_count});
            state_nxt = ST_ACC;
          end else begin
            m_nxt     = in_observed_count;
            sh_nxt    = '0;
            step_nxt  = '0;
            sel_v_nxt = 1'b0;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // binary search for the leading one: 16, 8, 4, 2, 1
        if ((m_r & top_mask) == '0) begin
          m_nxt  = m_r << norm_amt;
          sh_nxt = sh_r + norm_amt;
        end
        if (step_r == LAST_NORM) begin
          step_nxt  = '0;
          frac_nxt  = '0;
          state_nxt = ST_SQ;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SQ: begin
        frac_nxt = {frac_r[F-2:0], m_sq[CW]};
        m_nxt    = m_sq[CW] ? m_sq[CW:1] : m_sq[CW-1:0];
        if (step_r == LAST_SQ) begin
          step_nxt  = '0;
          state_nxt = ST_LN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_LN: begin
        // ln = floor(log2 * ln2 / 2^32)
        if (!sel_v_r) begin
          ln_n_nxt  = product[32 +: LW];
          m_nxt     = v_r;
          sh_nxt    = '0;
          step_nxt  = '0;
          sel_v_nxt = 1'b1;
          state_nxt = ST_NORM;
        end else begin
          ln_v_nxt  = product[32 +: LW];
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        term_nxt  = v_minus_n + $signed(product[F +: TW]);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (acc_sum > $signed({{(ACC_W-SW){1'b0}}, pda_pkg::SUM_POS_LIMIT})) begin
          sum_nxt  = pda_pkg::SUM_POS_LIMIT;
          clip_nxt = 1'b1;
        end else if (acc_sum < $signed({{(ACC_W-SW){1'b1}}, pda_pkg::SUM_NEG_LIMIT})) begin
          sum_nxt  = pda_pkg::SUM_NEG_LIMIT;
          clip_nxt = 1'b1;
        end else begin
          sum_nxt = acc_sum[SW-1:0];
        end
        if (used_r != {BW{1'b1}}) begin
          used_nxt = used_r + 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          if ((sum_hi == '0) || (sum_hi == '1)) begin
            dev_nxt = {sum_r[pda_pkg::OUT_W-2:0], 1'b0};
            sat_nxt = clip_r;
          end else begin
            dev_nxt = sum_r[SW-1] ? pda_pkg::OUT_NEG_LIMIT : pda_pkg::OUT_POS_LIMIT;
            sat_nxt = 1'b1;
          end
          used_out_nxt  = used_r;
          out_valid_nxt = 1'b1;
          bin_nxt       = '0;
          used_nxt      = '0;
          sum_nxt       = '0;
          clip_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_bin_r <= BW'(1);
      bin_r       <= '0;
      used_r      <= '0;
      sum_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_bin_r <= first_bin_nxt;
      bin_r       <= bin_nxt;
      used_r      <= used_nxt;
      sum_r       <= sum_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    m_r        <= m_nxt;
    sh_r       <= sh_nxt;
    step_r     <= step_nxt;
    frac_r     <= frac_nxt;
    sel_v_r    <= sel_v_nxt;
    ln_n_r     <= ln_n_nxt;
    ln_v_r     <= ln_v_nxt;
    term_r     <= term_nxt;
    dev_r      <= dev_nxt;
    sat_r      <= sat_nxt;
    used_out_r <= used_out_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_deviance  = dev_r;
  assign out_saturated = sat_r;
  assign out_bins_used = used_out_r;

  // busy after every accepted bin
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block accepted a bin without going busy");

  // squaring counter stays below the fraction width
  a_sq_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (step_r <= LAST_SQ))
    else $error("squaring step out of range");

  // used bins never outnumber bins seen
  a_used_le_bins: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= bin_r)
    else $error("used bin count exceeds bin number");

  // emitting a result clears the histogram state
  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && last_r && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && bin_r == '0 && used_r == '0 && sum_r == '0 && !clip_r))
    else $error("state not cleared after result");

endmodule
